[sv/pidc_pkg.sv]
package pidc_pkg;

   // Fixed widths of the register file and gain formats
   localparam int GAIN_W    = 16;
   localparam int LIMIT_W   = 16;
   localparam int ILIM_W    = 31;
   localparam int PERIOD_W  = 16;
   localparam int CSR_W     = 31;
   localparam int CSR_IDX_W = 3;

   // Integral accumulator, derivative saturation and final sum widths
   localparam int IACC_W = 32;
   localparam int DSAT_W = 48;
   localparam int LO_W   = 24;
   localparam int SUM_W  = 64;
   localparam logic signed [SUM_W-1:0] DSAT_MAX = 64'sd70368744177664;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_LOW_LIMIT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_HIGH_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_LIMIT    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CONTROL_PERIOD = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_INVERSE_PERIOD = 3'd7;

   // Register reset values
   localparam logic signed [LIMIT_W-1:0] RST_OUT_LOW  = -16'sd32768;
   localparam logic signed [LIMIT_W-1:0] RST_OUT_HIGH = 16'sd32767;
   localparam logic [ILIM_W-1:0]         RST_ILIM     = 31'h7FFF_FFFF;
   localparam logic [PERIOD_W-1:0]       RST_PERIOD   = 16'd66;
   localparam logic [PERIOD_W-1:0]       RST_INV      = 16'd1000;

   typedef struct packed {
      logic signed [GAIN_W-1:0]  prop_gain;
      logic signed [GAIN_W-1:0]  integ_gain;
      logic signed [GAIN_W-1:0]  deriv_gain;
      logic signed [LIMIT_W-1:0] out_low_limit;
      logic signed [LIMIT_W-1:0] out_high_limit;
      logic [ILIM_W-1:0]         integ_limit;
      logic [PERIOD_W-1:0]       control_period;
      logic [PERIOD_W-1:0]       inverse_period;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INC,
      ST_PROP,
      ST_INTEG,
      ST_DERIV,
      ST_SAT,
      ST_DLO,
      ST_DHI,
      ST_ADDHI,
      ST_OUT
   } state_type;

   // Operand selection for the shared multiplier
   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_INC,
      MUL_PROP,
      MUL_INTEG,
      MUL_DERIV,
      MUL_DLO,
      MUL_DHI
   } mul_sel_type;

   // What the sum accumulator adds this cycle
   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_ADD_P,
      ACC_ADD_I,
      ACC_ADD_LO,
      ACC_ADD_HI
   } acc_op_type;

   typedef struct packed {
      logic        capture;
      mul_sel_type mul_sel;
      logic        integ_update;
      logic        dsat_load;
      acc_op_type  acc_op;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

[sv/positional_pid_controller_unit.sv]
// Positional PID controller with integral anti-windup.
// Input channel (req_): one item is a setpoint and a measurement, taken
// when req_valid and req_ready are high together. Result channel (rsp_):
// one clamped drive value for every item, under the same handshake.
// Gains, limits and periods are set through the csr_ write port, one
// register per write; the user must write them only while no item is in
// flight, as the block itself does not enforce this. The single shared
// 33x17 multiplier forms, one after another, the integral increment, the
// P, I and D products and the two halves of the derivative times inverse
// period.
// req_ready is high only while the sequencer is idle; a new item can be
// taken while the previous result still waits in the output register.
// When the receiver stalls, the result stays in the output register and
// the sequencer holds its final step until that register frees up.
// Reset (synchronous, active high) clears the integral and last error,
// empties the output register and restores the register defaults.
module positional_pid_controller_unit #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [DATA_WIDTH-1:0]         req_target_value,
   input  logic signed [DATA_WIDTH-1:0]         req_measured_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [DATA_WIDTH-1:0]         rsp_drive_value,
   input  logic                                 csr_write_en,
   input  logic [pidc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pidc_pkg::CSR_W-1:0]           csr_write_data
);

   pidc_pkg::cfg_type    cfg_ff, cfg_in;
   pidc_pkg::cmd_type    cmd;
   pidc_pkg::status_type status;

   // Register file writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            pidc_pkg::REG_PROP_GAIN:      cfg_in.prop_gain      = csr_write_data[15:0];
            pidc_pkg::REG_INTEG_GAIN:     cfg_in.integ_gain     = csr_write_data[15:0];
            pidc_pkg::REG_DERIV_GAIN:     cfg_in.deriv_gain     = csr_write_data[15:0];
            pidc_pkg::REG_OUT_LOW_LIMIT:  cfg_in.out_low_limit  = csr_write_data[15:0];
            pidc_pkg::REG_OUT_HIGH_LIMIT: cfg_in.out_high_limit = csr_write_data[15:0];
            pidc_pkg::REG_INTEG_LIMIT:    cfg_in.integ_limit    = csr_write_data[30:0];
            pidc_pkg::REG_CONTROL_PERIOD: cfg_in.control_period = csr_write_data[15:0];
            pidc_pkg::REG_INVERSE_PERIOD: cfg_in.inverse_period = csr_write_data[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain      <= '0;
         cfg_ff.integ_gain     <= '0;
         cfg_ff.deriv_gain     <= '0;
         cfg_ff.out_low_limit  <= pidc_pkg::RST_OUT_LOW;
         cfg_ff.out_high_limit <= pidc_pkg::RST_OUT_HIGH;
         cfg_ff.integ_limit    <= pidc_pkg::RST_ILIM;
         cfg_ff.control_period <= pidc_pkg::RST_PERIOD;
         cfg_ff.inverse_period <= pidc_pkg::RST_INV;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pidc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pidc_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .cfg                (cfg_ff),
      .req_target_value   (req_target_value),
      .req_measured_value (req_measured_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_drive_value    (rsp_drive_value)
   );

endmodule

[sv/pidc_ctrl.sv]
module pidc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pidc_pkg::status_type  status,
   output pidc_pkg::cmd_type     cmd
);

   pidc_pkg::state_type state_ff;
   pidc_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pidc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Step sequence: at most one multiply per step, product consumed a step later
   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd.capture      = 1'b0;
      cmd.mul_sel      = pidc_pkg::MUL_NONE;
      cmd.integ_update = 1'b0;
      cmd.dsat_load    = 1'b0;
      cmd.acc_op       = pidc_pkg::ACC_NONE;
      cmd.out_load     = 1'b0;
      case (state_ff)
         pidc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = pidc_pkg::ST_INC;
            end
         end
         pidc_pkg::ST_INC: begin
            cmd.mul_sel = pidc_pkg::MUL_INC;
            state_in    = pidc_pkg::ST_PROP;
         end
         pidc_pkg::ST_PROP: begin
            cmd.mul_sel      = pidc_pkg::MUL_PROP;
            cmd.integ_update = 1'b1;
            state_in         = pidc_pkg::ST_INTEG;
         end
         pidc_pkg::ST_INTEG: begin
            cmd.mul_sel = pidc_pkg::MUL_INTEG;
            cmd.acc_op  = pidc_pkg::ACC_ADD_P;
            state_in    = pidc_pkg::ST_DERIV;
         end
         pidc_pkg::ST_DERIV: begin
            cmd.mul_sel = pidc_pkg::MUL_DERIV;
            cmd.acc_op  = pidc_pkg::ACC_ADD_I;
            state_in    = pidc_pkg::ST_SAT;
         end
         pidc_pkg::ST_SAT: begin
            cmd.dsat_load = 1'b1;
            state_in      = pidc_pkg::ST_DLO;
         end
         pidc_pkg::ST_DLO: begin
            cmd.mul_sel = pidc_pkg::MUL_DLO;
            state_in    = pidc_pkg::ST_DHI;
         end
         pidc_pkg::ST_DHI: begin
            cmd.mul_sel = pidc_pkg::MUL_DHI;
            cmd.acc_op  = pidc_pkg::ACC_ADD_LO;
            state_in    = pidc_pkg::ST_ADDHI;
         end
         pidc_pkg::ST_ADDHI: begin
            cmd.acc_op = pidc_pkg::ACC_ADD_HI;
            state_in   = pidc_pkg::ST_OUT;
         end
         pidc_pkg::ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = pidc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pidc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[sv/pidc_datapath.sv]
module pidc_datapath #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pidc_pkg::cmd_type            cmd,
   output pidc_pkg::status_type         status,
   input  pidc_pkg::cfg_type            cfg,
   input  logic signed [DATA_WIDTH-1:0] req_target_value,
   input  logic signed [DATA_WIDTH-1:0] req_measured_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_drive_value
);

   localparam int E_W    = DATA_WIDTH + 1;
   localparam int D_W    = DATA_WIDTH + 2;
   localparam int MA_W   = (DATA_WIDTH + 2 > 33) ? DATA_WIDTH + 2 : 33;
   localparam int MB_W   = 17;
   localparam int P_W    = MA_W + MB_W;
   localparam int INC_W  = P_W + 1;
   localparam int IACC_W = pidc_pkg::IACC_W;
   localparam int DSAT_W = pidc_pkg::DSAT_W;
   localparam int LO_W   = pidc_pkg::LO_W;
   localparam int SUM_W  = pidc_pkg::SUM_W;

   logic signed [E_W-1:0]    err_ff, err_in, last_error_ff;
   logic signed [D_W-1:0]    diff_ff, diff_in;
   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [P_W-1:0]    prod_ff, prod_in;
   logic signed [IACC_W-1:0] integral_ff, integral_in;
   logic signed [INC_W-1:0]  inc_sum, inc_lim;
   logic signed [DSAT_W-1:0] dsat_ff, dsat_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in, addend;
   logic signed [SUM_W-1:0]  y_shift, y_lim, out_hi, out_lo, dmax;
   logic signed [DATA_WIDTH-1:0] out_ff;
   logic                     out_valid_ff;

   // Error and error difference at capture
   assign err_in  = E_W'(req_target_value) - E_W'(req_measured_value);
   assign diff_in = D_W'(err_in) - D_W'(last_error_ff);

   // Shared multiplier operand selection
   always_comb begin
      case (cmd.mul_sel)
         pidc_pkg::MUL_INC: begin
            mul_a = MA_W'(err_ff);
            mul_b = signed'({1'b0, cfg.control_period});
         end
         pidc_pkg::MUL_PROP: begin
            mul_a = MA_W'(err_ff);
            mul_b = MB_W'(cfg.prop_gain);
         end
         pidc_pkg::MUL_INTEG: begin
            mul_a = MA_W'(integral_ff);
            mul_b = MB_W'(cfg.integ_gain);
         end
         pidc_pkg::MUL_DERIV: begin
            mul_a = MA_W'(diff_ff);
            mul_b = MB_W'(cfg.deriv_gain);
         end
         pidc_pkg::MUL_DLO: begin
            mul_a = MA_W'(signed'({1'b0, dsat_ff[LO_W-1:0]}));
            mul_b = signed'({1'b0, cfg.inverse_period});
         end
         pidc_pkg::MUL_DHI: begin
            mul_a = MA_W'(signed'(dsat_ff[DSAT_W-1:LO_W]));
            mul_b = signed'({1'b0, cfg.inverse_period});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Integral update with symmetric anti-windup clamp
   always_comb begin
      inc_sum = INC_W'(integral_ff) + INC_W'(prod_ff);
      inc_lim = INC_W'(signed'({1'b0, cfg.integ_limit}));
      if (inc_sum > inc_lim) begin
         integral_in = IACC_W'(inc_lim);
      end else if (inc_sum < -inc_lim) begin
         integral_in = IACC_W'(-inc_lim);
      end else begin
         integral_in = IACC_W'(inc_sum);
      end
   end

   // Derivative product saturated to +/- 2^46
   always_comb begin
      if (prod_ff > P_W'(pidc_pkg::DSAT_MAX)) begin
         dsat_in = DSAT_W'(pidc_pkg::DSAT_MAX);
      end else if (prod_ff < -P_W'(pidc_pkg::DSAT_MAX)) begin
         dsat_in = DSAT_W'(-pidc_pkg::DSAT_MAX);
      end else begin
         dsat_in = DSAT_W'(prod_ff);
      end
   end

   // Q8 sum of the three terms
   always_comb begin
      case (cmd.acc_op)
         pidc_pkg::ACC_ADD_P:  addend = SUM_W'(prod_ff);
         pidc_pkg::ACC_ADD_I:  addend = SUM_W'(prod_ff >>> 16);
         pidc_pkg::ACC_ADD_LO: addend = SUM_W'(prod_ff);
         pidc_pkg::ACC_ADD_HI: addend = SUM_W'(prod_ff) <<< LO_W;
         default:              addend = '0;
      endcase
      sum_in = cmd.capture ? '0 : sum_ff + addend;
   end

   // Floor to integer, output limits, then the data width range
   always_comb begin
      y_shift = sum_ff >>> 8;
      out_hi  = SUM_W'(cfg.out_high_limit);
      out_lo  = SUM_W'(cfg.out_low_limit);
      dmax    = SUM_W'(signed'({1'b0, {(DATA_WIDTH-1){1'b1}}}));
      if (y_shift > out_hi) begin
         y_lim = out_hi;
      end else if (y_shift < out_lo) begin
         y_lim = out_lo;
      end else begin
         y_lim = y_shift;
      end
      if (y_lim > dmax) begin
         y_lim = dmax;
      end else if (y_lim < ~dmax) begin
         y_lim = ~dmax;
      end
   end

   // Loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff   <= '0;
         last_error_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.integ_update) begin
            integral_ff <= integral_in;
         end
         if (cmd.out_load) begin
            last_error_ff <= err_ff;
            out_valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      if (cmd.capture) begin
         err_ff  <= err_in;
         diff_ff <= diff_in;
      end
      if (cmd.dsat_load) begin
         dsat_ff <= dsat_in;
      end
      if (cmd.out_load) begin
         out_ff <= y_lim[DATA_WIDTH-1:0];
      end
   end

   assign status.out_free = !out_valid_ff || rsp_ready;
   assign rsp_valid       = out_valid_ff;
   assign rsp_drive_value = out_ff;

endmodule
